### src/dsmt_pkg.sv
package dsmt_pkg;

    // Item numbers travel on an 8-bit field; at most 256 distinct items exist
    localparam int ITEM_W     = 8;
    localparam int ITEM_SPACE = 256;

    typedef enum logic
    {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t              mode;
        logic [ITEM_W-1:0]  item;
    } cmd_t;

    typedef struct packed
    {
        logic [ITEM_W-1:0]  popped_item;
        logic               underflow;
        logic               was_present;
        logic               now_empty;
    } res_t;

    // One stack position
    typedef struct packed
    {
        logic               valid;
        logic [ITEM_W-1:0]  item;
    } slot_t;

    // Cell moves: hold, take the slot above, take the slot below
    typedef enum logic [1:0]
    {
        CELL_HOLD = 2'd0,
        CELL_DOWN = 2'd1,
        CELL_UP   = 2'd2
    } cell_op_t;

    // Broadcast to every cell; on CELL_DOWN only cells whose index is at most limit move
    typedef struct packed
    {
        cell_op_t           op;
        logic [ITEM_W-1:0]  limit;
    } cell_ctl_t;

endpackage

### src/dedup_stack_move_to_top_core.sv
// Stack of distinct item numbers with move-to-top on a repeated push. The
// stack lives in a row of cells, one per position, top at cell 0; push
// shifts cells down (only down to the old place of a repeated item), pop
// shifts them up and returns the top. A pop of an empty stack returns
// underflow and changes nothing; a push of an item number at or above
// ITEM_COUNT is ignored. A transaction runs through these steps before the
// next acceptance: every cell matches the item as it is accepted, the match
// position is encoded (S_FIND), then the cells shift and the result register
// loads (S_APPLY). The result register lets a new command be accepted while
// a result waits; the shift step stalls only if the previous result is still
// not taken. Reset empties the stack at once.
module dedup_stack_move_to_top_core #(
    parameter int ITEM_COUNT = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  dsmt_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output dsmt_pkg::res_t  res
);
    import dsmt_pkg::*;

    localparam int DEPTH = (ITEM_COUNT < ITEM_SPACE) ? ITEM_COUNT : ITEM_SPACE;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_FIND,
        S_APPLY
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [ITEM_W-1:0]  item_reg;
    logic [ITEM_W-1:0]  item_next;
    logic [ITEM_W-1:0]  pos_reg;
    logic [ITEM_W-1:0]  pos_next;
    logic               found_reg;
    logic               found_next;
    res_t               res_reg;
    res_t               res_next;
    logic               res_valid_reg;
    logic               res_valid_next;

    logic [ITEM_W-1:0]  key;
    cell_ctl_t          ctl;
    slot_t              slots [DEPTH];
    logic [DEPTH-1:0]   hits;
    logic [ITEM_W-1:0]  enc_pos;
    logic               enc_any;
    logic               in_range;
    logic               slot_free;

    // Match key: the incoming item while idle, the held item afterwards
    assign key = (state_reg == S_IDLE) ? cmd.item : item_reg;

    // Cell row
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        slot_t above;
        slot_t below;

        if (g == 0)
        begin : g_top
            assign above.valid = 1'b1;
            assign above.item  = item_reg;
        end
        else
        begin : g_mid
            assign above = slots[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign below = '0;
        end
        else
        begin : g_inner
            assign below = slots[g+1];
        end

        dsmt_cell #(
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .key        (key),
            .from_above (above),
            .from_below (below),
            .slot       (slots[g]),
            .hit        (hits[g])
        );
    end

    dsmt_enc #(
        .DEPTH (DEPTH)
    ) u_enc (
        .hits (hits),
        .pos  (enc_pos),
        .any  (enc_any)
    );

    assign in_range  = (32'(item_reg) < 32'(ITEM_COUNT));
    assign slot_free = !res_valid_reg || res_ready;

    // Cell command and result for the shift step
    always_comb
    begin
        ctl.op    = CELL_HOLD;
        ctl.limit = found_reg ? pos_reg : ITEM_W'(DEPTH - 1);
        res_next  = res_reg;

        if (state_reg == S_APPLY && slot_free)
        begin
            res_next = '0;
            if (mode_reg == MODE_PUSH)
            begin
                if (in_range)
                begin
                    ctl.op               = CELL_DOWN;
                    res_next.was_present = found_reg;
                    res_next.now_empty   = 1'b0;
                end
                else
                begin
                    res_next.now_empty = !slots[0].valid;
                end
            end
            else
            begin
                if (slots[0].valid)
                begin
                    ctl.op               = CELL_UP;
                    res_next.popped_item = slots[0].item;
                    res_next.now_empty   = !slots[1].valid;
                end
                else
                begin
                    res_next.underflow = 1'b1;
                    res_next.now_empty = 1'b1;
                end
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        item_next      = item_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next  = cmd.mode;
                    item_next  = cmd.item;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                pos_next   = enc_pos;
                found_next = enc_any;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            mode_reg      <= MODE_PUSH;
            item_reg      <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            mode_reg      <= mode_next;
            item_reg      <= item_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            res_reg       <= res_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### src/dsmt_cell.sv
module dsmt_cell #(
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dsmt_pkg::cell_ctl_t      ctl,
    input  logic [dsmt_pkg::ITEM_W-1:0] key,
    input  dsmt_pkg::slot_t          from_above,
    input  dsmt_pkg::slot_t          from_below,
    output dsmt_pkg::slot_t          slot,
    output logic                     hit
);
    import dsmt_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [ITEM_W-1:0]  item_reg;
    logic [ITEM_W-1:0]  item_next;
    logic               hit_reg;
    logic               hit_next;
    logic               in_window;

    // Position 0 is the top; a push shifts every cell down to the old place of the item
    assign in_window = (ITEM_W'(INDEX) <= ctl.limit);

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        case (ctl.op)
            CELL_DOWN:
            begin
                if (in_window)
                begin
                    valid_next = from_above.valid;
                    item_next  = from_above.item;
                end
            end
            CELL_UP:
            begin
                valid_next = from_below.valid;
                item_next  = from_below.item;
            end
            default:
            begin
                valid_next = valid_reg;
                item_next  = item_reg;
            end
        endcase
    end

    // Local match against the broadcast key
    assign hit_next = valid_reg && (item_reg == key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign slot.valid = valid_reg;
    assign slot.item  = item_reg;
    assign hit        = hit_reg;

endmodule

### src/dsmt_enc.sv
module dsmt_enc #(
    parameter int DEPTH = 256
) (
    input  logic [DEPTH-1:0]            hits,
    output logic [dsmt_pkg::ITEM_W-1:0] pos,
    output logic                        any
);
    import dsmt_pkg::*;

    // Items are distinct, so at most one hit: OR of the indexes gives its position
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            pos = pos | (hits[i] ? ITEM_W'(i) : '0);
        end
    end

    assign any = |hits;

endmodule

### src/dsmt_checker.sv
module dsmt_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  logic            res_valid,
    input  logic            res_ready,
    input  dsmt_pkg::res_t  res
);
    import dsmt_pkg::*;

    // A result held back by the consumer stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // The sequencer is busy in the cycle after a transaction is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted twice in a row");

    // Underflow means an empty stack and nothing returned
    a_underflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.underflow |->
            res.now_empty && (res.popped_item == '0) && !res.was_present)
        else $error("inconsistent underflow result");

    // A repeated push leaves the item on top, so the stack cannot be empty
    a_present_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.was_present |-> !res.now_empty && !res.underflow)
        else $error("repeated push reported an empty stack");

endmodule

bind dedup_stack_move_to_top_core dsmt_checker u_dsmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
